[rtl/apms_pkg.sv]
package apms_pkg;

    localparam int PATTERN_MAX = 32;
    localparam int IDX_W       = $clog2(PATTERN_MAX);
    localparam int DIST_W      = 6;
    localparam int CHAR_W      = 8;
    localparam int POS_W       = 16;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int PAT_W       = PATTERN_MAX * CHAR_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LENGTH = 3'd0,
        CFG_MAX_ERRORS     = 3'd1,
        CFG_PATTERN_0      = 3'd2,
        CFG_PATTERN_1      = 3'd3,
        CFG_PATTERN_2      = 3'd4,
        CFG_PATTERN_3      = 3'd5
    } t_cfg_reg;

    // data handed from one cell to the next
    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              restart;
        logic [POS_W-1:0]  position;
        logic [DIST_W-1:0] above_old;
        logic [DIST_W-1:0] above_new;
        logic [DIST_W-1:0] distance;
    } t_item;

    function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] v);
        logic [DIST_W-1:0] r;
        if (v >= DIST_W'(PATTERN_MAX)) begin
            r = DIST_W'(PATTERN_MAX);
        end else begin
            r = v + DIST_W'(1);
        end
        return r;
    endfunction

    function automatic logic [DIST_W-1:0] row_init(input logic [IDX_W-1:0] idx);
        logic [DIST_W:0] v;
        logic [DIST_W-1:0] r;
        v = (DIST_W+1)'(idx) + (DIST_W+1)'(1);
        if (v > (DIST_W+1)'(PATTERN_MAX)) begin
            r = DIST_W'(PATTERN_MAX);
        end else begin
            r = v[DIST_W-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/apms_cell.sv]
module apms_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [apms_pkg::IDX_W-1:0]  i_index,
    input  logic [apms_pkg::CHAR_W-1:0] i_pat_char,
    input  logic                        i_tap,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  apms_pkg::t_item             i_item,
    output logic                        o_valid,
    input  logic                        i_ready,
    output apms_pkg::t_item             o_item
);

    logic [apms_pkg::DIST_W-1:0] r_dist;
    logic                        r_valid;
    apms_pkg::t_item             r_item;

    logic [apms_pkg::DIST_W-1:0] old_eff;
    logic [apms_pkg::DIST_W-1:0] del_cost;
    logic [apms_pkg::DIST_W-1:0] ins_cost;
    logic [apms_pkg::DIST_W-1:0] diag_cost;
    logic [apms_pkg::DIST_W-1:0] n_dist;
    apms_pkg::t_item             n_item;
    logic                        take;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    always_comb begin
        old_eff   = i_item.restart ? apms_pkg::row_init(i_index) : r_dist;
        del_cost  = apms_pkg::sat_inc(old_eff);
        ins_cost  = apms_pkg::sat_inc(i_item.above_new);
        diag_cost = (i_pat_char != i_item.text_char)
                    ? apms_pkg::sat_inc(i_item.above_old) : i_item.above_old;
        n_dist = del_cost;
        if (ins_cost < n_dist) begin
            n_dist = ins_cost;
        end
        if (diag_cost < n_dist) begin
            n_dist = diag_cost;
        end
        n_item           = i_item;
        n_item.above_old = old_eff;
        n_item.above_new = n_dist;
        n_item.distance  = i_tap ? n_dist : i_item.distance;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_dist  <= apms_pkg::row_init(i_index);
        end else if (take) begin
            r_valid <= 1'b1;
            r_dist  <= n_dist;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[rtl/approximate_pattern_match_stream.sv]
// each input transfer passes through the stage register of every cell before its result reaches the master side
// throughput: one byte per cycle while the master side is ready, one systolic cell per pattern row
// each cell holds its stage register, so a stalled output only holds back cells that are full
// reset (synchronous, active low): pattern length 1, other registers 0, column at row index plus one,
// text position 0, no items in flight
module approximate_pattern_match_stream (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [apms_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [apms_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [7:0]                     i_s_tdata,   // text_char
    input  logic [0:0]                     i_s_tuser,   // restart_before
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [23:0]                    o_m_tdata    // end_position, edit_distance, is_match
);

    localparam int N = apms_pkg::PATTERN_MAX;

    logic [apms_pkg::DIST_W-1:0] r_pattern_length;
    logic [apms_pkg::DIST_W-1:0] r_max_errors;
    logic [apms_pkg::PAT_W-1:0]  r_pattern;
    logic [apms_pkg::POS_W-1:0]  r_position;
    logic [apms_pkg::POS_W-1:0]  n_position;

    logic [apms_pkg::DIST_W-1:0] len_eff;
    logic [apms_pkg::DIST_W-1:0] tap_row;

    logic                        valid [N+1];
    logic                        ready [N+1];
    apms_pkg::t_item             item  [N+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_length <= apms_pkg::DIST_W'(1);
            r_max_errors     <= '0;
            r_pattern        <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                apms_pkg::CFG_PATTERN_LENGTH: begin
                    r_pattern_length <= i_cfg_data[apms_pkg::DIST_W-1:0];
                end
                apms_pkg::CFG_MAX_ERRORS: begin
                    r_max_errors <= i_cfg_data[apms_pkg::DIST_W-1:0];
                end
                apms_pkg::CFG_PATTERN_0: begin
                    r_pattern[0*apms_pkg::CFG_W +: apms_pkg::CFG_W] <= i_cfg_data;
                end
                apms_pkg::CFG_PATTERN_1: begin
                    r_pattern[1*apms_pkg::CFG_W +: apms_pkg::CFG_W] <= i_cfg_data;
                end
                apms_pkg::CFG_PATTERN_2: begin
                    r_pattern[2*apms_pkg::CFG_W +: apms_pkg::CFG_W] <= i_cfg_data;
                end
                apms_pkg::CFG_PATTERN_3: begin
                    r_pattern[3*apms_pkg::CFG_W +: apms_pkg::CFG_W] <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_pattern_length == '0) begin
            len_eff = apms_pkg::DIST_W'(1);
        end else if (r_pattern_length > apms_pkg::DIST_W'(N)) begin
            len_eff = apms_pkg::DIST_W'(N);
        end else begin
            len_eff = r_pattern_length;
        end
        tap_row = len_eff - apms_pkg::DIST_W'(1);
    end

    // text position is stamped on entry
    always_comb begin
        item[0].text_char = i_s_tdata;
        item[0].restart   = i_s_tuser[0];
        item[0].position  = i_s_tuser[0] ? '0 : r_position;
        item[0].above_old = '0;
        item[0].above_new = '0;
        item[0].distance  = '0;
        n_position        = item[0].position + apms_pkg::POS_W'(1);
    end

    assign valid[0]   = i_s_tvalid;
    assign o_s_tready = ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= '0;
        end else if (i_s_tvalid && ready[0]) begin
            r_position <= n_position;
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_cell
        apms_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_index    (apms_pkg::IDX_W'(g)),
            .i_pat_char (r_pattern[g*apms_pkg::CHAR_W +: apms_pkg::CHAR_W]),
            .i_tap      (tap_row == apms_pkg::DIST_W'(g)),
            .i_valid    (valid[g]),
            .o_ready    (ready[g]),
            .i_item     (item[g]),
            .o_valid    (valid[g+1]),
            .i_ready    (ready[g+1]),
            .o_item     (item[g+1])
        );
    end

    assign ready[N]   = i_m_tready;
    assign o_m_tvalid = valid[N];
    assign o_m_tdata  = {1'b0, (item[N].distance <= r_max_errors), item[N].distance,
                         item[N].position};

endmodule

[dv/testbench.sv]
module testbench;

    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 145;
    localparam int PHASES = 8;
    localparam logic [apms_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [apms_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [apms_pkg::POS_W-1:0]  pos;
        logic [apms_pkg::DIST_W-1:0] distance;
        logic                        hit;
    } t_match_result;

    typedef enum logic {ROW_ITEM, ROW_SETUP} t_row_kind;
    typedef enum logic [2:0] {PAT_ZERO, PAT_ALPHA, PAT_ONES, PAT_SMALL, PAT_RANDOM} t_pat_kind;

    typedef struct packed {
        t_row_kind                   kind;
        logic [apms_pkg::CHAR_W-1:0] c;
        logic                        rs;
        logic                        typed;
        t_match_result               want;
        logic [apms_pkg::DIST_W-1:0] len;
        logic [apms_pkg::DIST_W-1:0] errs;
        t_pat_kind                   pat;
    } t_script_row;

    logic                           i_clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [apms_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [apms_pkg::CFG_W-1:0]     cfg_data;
    logic                           s_valid;
    logic                           o_s_tready;
    logic [7:0]                     s_data;     // text_char
    logic [0:0]                     s_user;     // restart_before
    logic                           o_m_tvalid;
    logic                           m_ready;
    logic [23:0]                    o_m_tdata;  // end_position, edit_distance, is_match

    logic calm = 1'b0;
    logic hold_req = 1'b0;
    int   mismatches = 0;
    int   cycle_count = 0;

    // predictor state and register copies
    logic [apms_pkg::DIST_W-1:0] col_dist [apms_pkg::PATTERN_MAX];
    logic [apms_pkg::POS_W-1:0]  text_pos;
    logic [apms_pkg::DIST_W-1:0] cfg_len;
    logic [apms_pkg::DIST_W-1:0] cfg_errs;
    logic [apms_pkg::PAT_W-1:0]  pat_bytes;

    t_match_result pending_results [$];

    t_script_row script [$] = '{
        '{ROW_ITEM,  8'h00, 1'b0, 1'b1, '{16'd0, 6'd0, 1'b1}, 6'd0,  6'd0,  PAT_ZERO},
        '{ROW_ITEM,  8'hff, 1'b0, 1'b1, '{16'd1, 6'd1, 1'b0}, 6'd0,  6'd0,  PAT_ZERO},
        '{ROW_ITEM,  8'h00, 1'b1, 1'b1, '{16'd0, 6'd0, 1'b1}, 6'd0,  6'd0,  PAT_ZERO},
        '{ROW_ITEM,  8'h80, 1'b0, 1'b1, '{16'd1, 6'd1, 1'b0}, 6'd0,  6'd0,  PAT_ZERO},
        '{ROW_ITEM,  8'h01, 1'b0, 1'b1, '{16'd2, 6'd1, 1'b0}, 6'd0,  6'd0,  PAT_ZERO},
        // zero length acts as length one
        '{ROW_SETUP, 8'h00, 1'b0, 1'b0, '0,                   6'd0,  6'd1,  PAT_ALPHA},
        '{ROW_ITEM,  8'h61, 1'b0, 1'b1, '{16'd3, 6'd0, 1'b1}, 6'd0,  6'd0,  PAT_ZERO},
        '{ROW_ITEM,  8'h7a, 1'b0, 1'b1, '{16'd4, 6'd1, 1'b1}, 6'd0,  6'd0,  PAT_ZERO},
        '{ROW_SETUP, 8'h00, 1'b0, 1'b0, '0,                   6'd32, 6'd32, PAT_ALPHA},
        '{ROW_ITEM,  8'h61, 1'b1, 1'b0, '0,                   6'd0,  6'd0,  PAT_ZERO},
        '{ROW_ITEM,  8'h62, 1'b0, 1'b0, '0,                   6'd0,  6'd0,  PAT_ZERO},
        '{ROW_ITEM,  8'h63, 1'b0, 1'b0, '0,                   6'd0,  6'd0,  PAT_ZERO},
        '{ROW_ITEM,  8'h65, 1'b0, 1'b0, '0,                   6'd0,  6'd0,  PAT_ZERO},
        '{ROW_ITEM,  8'h00, 1'b0, 1'b0, '0,                   6'd0,  6'd0,  PAT_ZERO},
        '{ROW_ITEM,  8'hff, 1'b0, 1'b0, '0,                   6'd0,  6'd0,  PAT_ZERO},
        // length above the maximum, every distance a match, saturation
        '{ROW_SETUP, 8'h00, 1'b0, 1'b0, '0,                   6'd63, 6'd63, PAT_ONES},
        '{ROW_ITEM,  8'hff, 1'b1, 1'b0, '0,                   6'd0,  6'd0,  PAT_ZERO},
        '{ROW_ITEM,  8'hff, 1'b0, 1'b0, '0,                   6'd0,  6'd0,  PAT_ZERO},
        '{ROW_ITEM,  8'h00, 1'b0, 1'b0, '0,                   6'd0,  6'd0,  PAT_ZERO},
        '{ROW_ITEM,  8'hff, 1'b0, 1'b0, '0,                   6'd0,  6'd0,  PAT_ZERO},
        '{ROW_SETUP, 8'h00, 1'b0, 1'b0, '0,                   6'd5,  6'd2,  PAT_ALPHA},
        '{ROW_ITEM,  8'h61, 1'b1, 1'b0, '0,                   6'd0,  6'd0,  PAT_ZERO},
        '{ROW_ITEM,  8'h62, 1'b0, 1'b0, '0,                   6'd0,  6'd0,  PAT_ZERO},
        '{ROW_ITEM,  8'h7f, 1'b0, 1'b0, '0,                   6'd0,  6'd0,  PAT_ZERO},
        '{ROW_ITEM,  8'h63, 1'b0, 1'b0, '0,                   6'd0,  6'd0,  PAT_ZERO},
        '{ROW_ITEM,  8'h64, 1'b0, 1'b0, '0,                   6'd0,  6'd0,  PAT_ZERO}
    };

    approximate_pattern_match_stream dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_valid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_data),
        .i_s_tuser   (s_user),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_ready),
        .o_m_tdata   (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #4 i_clk = ~i_clk;
        end
    end

    function automatic logic [apms_pkg::DIST_W-1:0] grow(input logic [apms_pkg::DIST_W-1:0] v);
        return (v >= apms_pkg::DIST_W'(apms_pkg::PATTERN_MAX))
               ? apms_pkg::DIST_W'(apms_pkg::PATTERN_MAX) : v + 1'b1;
    endfunction

    function automatic int used_rows();
        return (cfg_len == 0) ? 1
               : (cfg_len > apms_pkg::PATTERN_MAX) ? apms_pkg::PATTERN_MAX : int'(cfg_len);
    endfunction

    function automatic void clear_column();
        for (int r = 0; r < apms_pkg::PATTERN_MAX; r++) begin
            col_dist[r] = (r + 1 > apms_pkg::PATTERN_MAX)
                          ? apms_pkg::DIST_W'(apms_pkg::PATTERN_MAX) : apms_pkg::DIST_W'(r + 1);
        end
        text_pos = '0;
    endfunction

    // one column update of the edit-distance table for a text byte
    function automatic t_match_result advance_column(input logic [7:0] c, input logic rs);
        logic [apms_pkg::DIST_W-1:0] above_old;
        logic [apms_pkg::DIST_W-1:0] above_new;
        logic [apms_pkg::DIST_W-1:0] prior;
        logic [apms_pkg::DIST_W-1:0] best;
        logic [apms_pkg::DIST_W-1:0] via;
        t_match_result res;
        if (rs) begin
            clear_column();
        end
        above_old = '0;
        above_new = '0;
        for (int r = 0; r < apms_pkg::PATTERN_MAX; r++) begin
            prior = col_dist[r];
            best = grow(prior);
            via = grow(above_new);
            if (via < best) begin
                best = via;
            end
            via = (pat_bytes[8*r +: 8] == c) ? above_old : grow(above_old);
            if (via < best) begin
                best = via;
            end
            col_dist[r] = best;
            above_old = prior;
            above_new = best;
        end
        res.pos = text_pos;
        res.distance = col_dist[used_rows() - 1];
        res.hit = (res.distance <= cfg_errs);
        text_pos = text_pos + 1'b1;
        return res;
    endfunction

    function automatic logic [apms_pkg::PAT_W-1:0] make_pattern(input t_pat_kind kind);
        logic [apms_pkg::PAT_W-1:0] p;
        for (int i = 0; i < apms_pkg::PATTERN_MAX; i++) begin
            case (kind)
                PAT_ZERO:  p[8*i +: 8] = 8'h00;
                PAT_ALPHA: p[8*i +: 8] = 8'h61 + 8'(i);
                PAT_ONES:  p[8*i +: 8] = 8'hff;
                PAT_SMALL: p[8*i +: 8] = 8'h61 + 8'($urandom_range(0, 3));
                default:   p[8*i +: 8] = 8'($urandom);
            endcase
        end
        return p;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic push_byte(input logic [7:0] c, input logic rs, input logic typed,
                             input t_match_result given);
        t_match_result res;
        while (!calm && $urandom_range(0, 99) < 18) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= c;
        s_user  <= rs;
        do @(posedge i_clk); while (!o_s_tready);
        res = advance_column(c, rs);
        pending_results.push_back(typed ? given : res);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // leaves the write enable low at the end; upper data bits of the length and error writes are random noise
    task automatic load_config(input logic [apms_pkg::DIST_W-1:0] len,
                               input logic [apms_pkg::DIST_W-1:0] errs,
                               input logic [apms_pkg::PAT_W-1:0] pat);
        apms_pkg::t_cfg_reg idx;
        logic [63:0]        data;
        for (int k = 0; k <= apms_pkg::CFG_PATTERN_3; k++) begin
            idx = apms_pkg::t_cfg_reg'(k);
            data = {$urandom, $urandom};
            case (idx)
                apms_pkg::CFG_PATTERN_LENGTH: data[apms_pkg::DIST_W-1:0] = len;
                apms_pkg::CFG_MAX_ERRORS:     data[apms_pkg::DIST_W-1:0] = errs;
                default: data = pat[64*(idx - apms_pkg::CFG_PATTERN_0) +: 64];
            endcase
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= data;
            @(posedge i_clk);
        end
        cfg_len = len;
        cfg_errs = errs;
        pat_bytes = pat;
        // index outside the register list must be ignored
        cfg_index <= apms_pkg::CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI));
        cfg_data  <= {$urandom, $urandom};
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // receiver side
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(0, 99) >= 18);
            end
        end
    end

    always @(posedge i_clk) begin
        t_match_result want;
        if (rst_n && o_m_tvalid && m_ready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected result %h", o_m_tdata));
            end else begin
                want = pending_results.pop_front();
                if (o_m_tdata[15:0] !== want.pos) begin
                    flag_mismatch($sformatf("end_position %0d, want %0d",
                                            o_m_tdata[15:0], want.pos));
                end
                if (o_m_tdata[21:16] !== want.distance) begin
                    flag_mismatch($sformatf("edit_distance %0d, want %0d at position %0d",
                                            o_m_tdata[21:16], want.distance, want.pos));
                end
                if (o_m_tdata[22] !== want.hit) begin
                    flag_mismatch($sformatf("is_match %b, want %b at position %0d",
                                            o_m_tdata[22], want.hit, want.pos));
                end
                if (o_m_tdata[23] !== 1'b0) begin
                    flag_mismatch("padding bit set");
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        logic [apms_pkg::DIST_W-1:0] len;
        logic [apms_pkg::DIST_W-1:0] errs;
        logic [7:0]                  c;
        logic                        rs;
        int                          rows;
        int                          walk;
        int                          e;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        s_user    <= '0;
        cfg_len = 6'd1;
        cfg_errs = '0;
        pat_bytes = '0;
        clear_column();
        repeat (6) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) begin
            if (script[i].kind == ROW_SETUP) begin
                wait_drained();
                load_config(script[i].len, script[i].errs, make_pattern(script[i].pat));
            end else begin
                push_byte(script[i].c, script[i].rs, script[i].typed, script[i].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            case (ph)
                0:       len = 6'd0;
                1:       len = 6'd32;
                3:       len = 6'($urandom_range(33, 63));
                default: len = 6'($urandom_range(1, 32));
            endcase
            case (ph)
                4:       errs = 6'd63;
                6:       errs = 6'd32;
                default: errs = 6'($urandom_range(0, 4));
            endcase
            load_config(len, errs, make_pattern((ph % 2) ? PAT_SMALL : PAT_RANDOM));
            calm = (ph == 2);
            if (ph == 5) begin
                hold_req = 1'b1;
            end
            rows = used_rows();
            walk = 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                rs = ($urandom_range(0, 99) < 2);
                if (walk < rows && $urandom_range(0, 99) < 80) begin
                    // walk the pattern with occasional edits
                    e = $urandom_range(0, 99);
                    if (e < 6) begin
                        c = 8'($urandom);
                        walk++;
                    end else if (e < 11) begin
                        c = 8'($urandom);
                    end else begin
                        if (e < 16) begin
                            walk++;
                        end
                        c = (walk < rows) ? pat_bytes[8*walk +: 8] : 8'($urandom);
                        walk++;
                    end
                end else begin
                    c = 8'($urandom);
                    if (walk >= rows && $urandom_range(0, 3) == 0) begin
                        walk = 0;
                    end
                end
                push_byte(c, rs, 1'b0, '0);
            end
        end
        calm = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
